>>> design/lir_pkg.sv
// lir_pkg: shared widths, constants, state type and step scaling for the
// linear interpolation resampler. No dependencies.
package lir_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 21;
    localparam int PHASE_W    = FRAC_BITS + 5;
    localparam int PROD_W     = SAMPLE_W + FRAC_BITS;
    localparam int STEP_EXT_W = STEP_W + 8;
    localparam int STEP_SHL   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int STEP_SHR   = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    localparam logic [STEP_W-1:0]  STEP_MIN   = STEP_W'(2048);
    localparam logic [STEP_W-1:0]  STEP_MAX   = STEP_W'(1048576);
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTERP,
        ST_SUM,
        ST_IWAIT,
        ST_REPEAT,
        ST_RWAIT
    } state_t;

    // clamp Q5.16 step to [1/32, 16] and rescale to FRAC_BITS fraction bits
    function automatic logic [PHASE_W-1:0] internal_step(input logic [STEP_W-1:0] s);
        logic [STEP_W-1:0]     c;
        logic [STEP_EXT_W-1:0] w;
        c = (s < STEP_MIN) ? STEP_MIN : ((s > STEP_MAX) ? STEP_MAX : s);
        w = (STEP_EXT_W'(c) << STEP_SHL) >> STEP_SHR;
        return w[PHASE_W-1:0];
    endfunction

endpackage

>>> design/lir_interp.sv
// lir_interp: shared multiply unit, s0 + trunc((s1 - s0) * frac).
// Product is registered on mul_en; result is valid the cycle after. Uses lir_pkg.
module lir_interp (
    input  logic                                 aclk,
    input  logic                                 mul_en,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]  s0,
    input  logic signed [lir_pkg::SAMPLE_W-1:0]  s1,
    input  logic        [lir_pkg::FRAC_BITS-1:0] frac,
    output logic signed [lir_pkg::SAMPLE_W-1:0]  result
);

    logic signed [lir_pkg::SAMPLE_W:0]   diff;
    logic        [lir_pkg::SAMPLE_W:0]   mag_wide;
    logic        [lir_pkg::SAMPLE_W-1:0] mag;
    logic                                neg;
    logic        [lir_pkg::PROD_W-1:0]   prod_reg;
    logic                                neg_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] base_reg;
    logic        [lir_pkg::SAMPLE_W-1:0] p;
    logic signed [lir_pkg::SAMPLE_W:0]   sum;

    always_comb begin
        diff     = {s1[lir_pkg::SAMPLE_W-1], s1} - {s0[lir_pkg::SAMPLE_W-1], s0};
        neg      = diff[lir_pkg::SAMPLE_W];
        mag_wide = neg ? -diff : diff;
        mag      = mag_wide[lir_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= lir_pkg::PROD_W'(mag) * lir_pkg::PROD_W'(frac);
            neg_reg  <= neg;
            base_reg <= s0;
        end
    end

    always_comb begin
        p      = prod_reg[lir_pkg::PROD_W-1:lir_pkg::FRAC_BITS];
        sum    = neg_reg ? ({base_reg[lir_pkg::SAMPLE_W-1], base_reg} - {1'b0, p})
                         : ({base_reg[lir_pkg::SAMPLE_W-1], base_reg} + {1'b0, p});
        result = sum[lir_pkg::SAMPLE_W-1:0];
    end

endmodule

>>> design/linear_interp_resampler.sv
// linear_interp_resampler: top level, sequencer, phase accumulator and step register.
// Depends on lir_pkg and lir_interp.
//
//  channel  | handshake           | payload
//  s_       | s_valid / s_ready   | s_sample_in[15:0], s_last_in
//  m_       | m_valid / m_ready   | m_sample_out[15:0], m_last_out
//  cfg_     | cfg_wr_en           | cfg_wr_data[20:0] (step, Q5.16)
//
// One transaction in at a time; s_ready is high only in idle.
// Per input: idle accepts it, each interpolated output passes through interpolate, sum
// and wait states, then an interpolate step closes (none on a stream's first sample);
// on a final input each repeated output passes through repeat and repeat-wait states,
// then a repeat step closes. m_ready low holds the sequencer in either wait state.
// Synchronous active-low reset returns to idle with step = 1.0 and no history.
module linear_interp_resampler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic        [lir_pkg::STEP_W-1:0]   cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic                                s_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic                                m_last_out
);

    lir_pkg::state_t state_reg, state_next;

    logic        [lir_pkg::STEP_W-1:0]   step_reg;
    logic        [lir_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic                                have_prev_reg, have_prev_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] cur_reg, cur_next;
    logic                                last_reg, last_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                                out_last_reg, out_last_next;

    logic [lir_pkg::PHASE_W-1:0]         step_int;
    logic [lir_pkg::PHASE_W-1:0]         phase_sum;
    logic                                phase_lt_one;
    logic                                mul_en;
    logic signed [lir_pkg::SAMPLE_W-1:0] interp_result;

    assign step_int     = lir_pkg::internal_step(step_reg);
    assign phase_sum    = phase_reg + step_int;
    assign phase_lt_one = (phase_reg[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] == '0);

    lir_interp u_interp (
        .aclk   (aclk),
        .mul_en (mul_en),
        .s0     (prev_reg),
        .s1     (cur_reg),
        .frac   (phase_reg[lir_pkg::FRAC_BITS-1:0]),
        .result (interp_result)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lir_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (have_prev_reg) begin
                        state_next = lir_pkg::ST_INTERP;
                    end else if (s_last_in) begin
                        state_next = lir_pkg::ST_REPEAT;
                    end
                end
            end
            lir_pkg::ST_INTERP: begin
                if (phase_lt_one) begin
                    state_next = lir_pkg::ST_SUM;
                end else if (last_reg) begin
                    state_next = lir_pkg::ST_REPEAT;
                end else begin
                    state_next = lir_pkg::ST_IDLE;
                end
            end
            lir_pkg::ST_SUM: begin
                state_next = lir_pkg::ST_IWAIT;
            end
            lir_pkg::ST_IWAIT: begin
                if (m_ready) begin
                    state_next = lir_pkg::ST_INTERP;
                end
            end
            lir_pkg::ST_REPEAT: begin
                state_next = phase_lt_one ? lir_pkg::ST_RWAIT : lir_pkg::ST_IDLE;
            end
            lir_pkg::ST_RWAIT: begin
                if (m_ready) begin
                    state_next = lir_pkg::ST_REPEAT;
                end
            end
            default: begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == lir_pkg::ST_IDLE);
        m_valid = (state_reg == lir_pkg::ST_IWAIT) || (state_reg == lir_pkg::ST_RWAIT);
        mul_en  = (state_reg == lir_pkg::ST_INTERP) && phase_lt_one;
    end

    assign m_sample_out = out_sample_reg;
    assign m_last_out   = out_last_reg;

    // datapath
    always_comb begin
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            lir_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cur_next  = s_sample_in;
                    last_next = s_last_in;
                    if (!have_prev_reg) begin
                        prev_next      = s_sample_in;
                        have_prev_next = 1'b1;
                        phase_next     = '0;
                    end
                end
            end
            lir_pkg::ST_INTERP: begin
                if (!phase_lt_one) begin
                    phase_next = phase_reg - lir_pkg::PHASE_ONE;
                    prev_next  = cur_reg;
                end
            end
            lir_pkg::ST_SUM: begin
                out_sample_next = interp_result;
                // final if no repeat follows: new phase at or past two
                out_last_next   = last_reg &&
                    (phase_sum[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS+1] != '0);
                phase_next      = phase_sum;
            end
            lir_pkg::ST_REPEAT: begin
                if (phase_lt_one) begin
                    out_sample_next = prev_reg;
                    out_last_next   =
                        (phase_sum[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] != '0);
                    phase_next      = phase_sum;
                end else begin
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    phase_next     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lir_pkg::ST_IDLE;
            step_reg      <= lir_pkg::STEP_RESET;
            phase_reg     <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input and output both open");

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS] <= 16)
        else $error("phase out of range");

    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lir_pkg::ST_IDLE) |->
            (phase_reg[lir_pkg::PHASE_W-1:lir_pkg::FRAC_BITS+4] == '0))
        else $error("idle phase not below step");

    a_fresh_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lir_pkg::ST_IDLE && !have_prev_reg) |-> (phase_reg == '0))
        else $error("phase not cleared at stream start");

    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_out) |=> ##[1:2] !have_prev_reg)
        else $error("stream not restarted after last transaction");
`endif

endmodule

>>> test/linear_interp_resampler_tb.sv
// linear_interp_resampler_tb: self-checking testbench for the linear interpolation
// resampler: directed edge cases, then random streams under several step settings.
// Depends on lir_pkg and linear_interp_resampler.
module linear_interp_resampler_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 250;
    localparam int MAX_PER_ITEM   = 64;
    localparam int MAX_REPORTS    = 50;

    typedef struct packed {
        logic signed [lir_pkg::SAMPLE_W-1:0] sample;
        logic                                last;
    } pcm_t;

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic        [lir_pkg::STEP_W-1:0]   cfg_wr_data = '0;
    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_in = '0;
    logic                                s_last_in   = 1'b0;
    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    logic signed [lir_pkg::SAMPLE_W-1:0] m_sample_out;
    logic                                m_last_out;

    pcm_t sample_q[$];
    pcm_t resampled_q[$];

    // predictor state
    logic        [lir_pkg::STEP_W-1:0]   step_cfg;
    logic signed [lir_pkg::SAMPLE_W-1:0] hist_sample;
    logic                                hist_valid;
    longint                              phase_acc;

    int   err_count  = 0;
    int   idle_count = 0;
    int   s_idle_pct = 0;
    int   m_idle_pct = 0;
    int   hold_left  = 0;
    logic hold_req   = 1'b0;
    logic hold_done  = 1'b0;
    logic s_took     = 1'b0;

    linear_interp_resampler u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out),
        .m_last_out  (m_last_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic longint scaled_step(input logic [lir_pkg::STEP_W-1:0] s);
        longint c;
        c = s;
        if (c < lir_pkg::STEP_MIN) c = lir_pkg::STEP_MIN;
        if (c > lir_pkg::STEP_MAX) c = lir_pkg::STEP_MAX;
        return (c << lir_pkg::FRAC_BITS) >> 16;
    endfunction

    // s0 + (s1 - s0) * frac, truncated toward zero
    function automatic logic signed [lir_pkg::SAMPLE_W-1:0] lerp(
        input logic signed [lir_pkg::SAMPLE_W-1:0] s0,
        input logic signed [lir_pkg::SAMPLE_W-1:0] s1,
        input longint                              frac);
        longint d, m, p;
        d = longint'(s1) - longint'(s0);
        m = (d < 0) ? -d : d;
        p = (m * frac) >>> lir_pkg::FRAC_BITS;
        return lir_pkg::SAMPLE_W'((d < 0) ? longint'(s0) - p : longint'(s0) + p);
    endfunction

    function automatic void resample_item(input pcm_t it);
        longint one, st;
        int     n;
        pcm_t   r;
        one = longint'(1) << lir_pkg::FRAC_BITS;
        st  = scaled_step(step_cfg);
        n   = 0;
        if (!hist_valid) begin
            hist_sample = it.sample;
            hist_valid  = 1'b1;
            phase_acc   = 0;
        end else begin
            while (phase_acc < one && n < MAX_PER_ITEM) begin
                r.sample = lerp(hist_sample, it.sample, phase_acc & (one - 1));
                r.last   = 1'b0;
                resampled_q.push_back(r);
                n++;
                phase_acc += st;
            end
            phase_acc  -= one;
            hist_sample = it.sample;
        end
        if (it.last) begin
            while (phase_acc < one && n < MAX_PER_ITEM) begin
                r.sample = hist_sample;
                r.last   = 1'b0;
                resampled_q.push_back(r);
                n++;
                phase_acc += st;
            end
            if (n > 0) begin
                r      = resampled_q.pop_back();
                r.last = 1'b1;
                resampled_q.push_back(r);
            end
            hist_sample = '0;
            hist_valid  = 1'b0;
            phase_acc   = 0;
        end
    endfunction

    // monitor, predictor update and watchdog
    always @(posedge aclk) begin
        pcm_t want;
        if (!aresetn) begin
            step_cfg    = lir_pkg::STEP_RESET;
            hist_sample = '0;
            hist_valid  = 1'b0;
            phase_acc   = 0;
        end else begin
            if (cfg_wr_en)
                step_cfg = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (resampled_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction sample=%0d last=%0b",
                                              m_sample_out, m_last_out));
                end else begin
                    want = resampled_q.pop_front();
                    if (m_sample_out !== want.sample)
                        report_mismatch($sformatf("sample_out got %0d exp %0d",
                                                  m_sample_out, want.sample));
                    if (m_last_out !== want.last)
                        report_mismatch($sformatf("last_out got %0b exp %0b",
                                                  m_last_out, want.last));
                end
            end
            if (s_valid && s_ready)
                resample_item({s_sample_in, s_last_in});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT @%0t: no transaction for %0d cycles", $time, idle_count);
                $display("linear_interp_resampler regression: fail");
                $finish;
            end
        end
        s_took <= s_valid && s_ready;
    end

    // input driver
    always @(negedge aclk) begin
        pcm_t nxt;
        if (aresetn && (!s_valid || s_took)) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                nxt = sample_q.pop_front();
                s_valid     <= 1'b1;
                s_sample_in <= nxt.sample;
                s_last_in   <= nxt.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    task automatic push_item(input int sample, input bit last);
        pcm_t it;
        it.sample = lir_pkg::SAMPLE_W'(sample);
        it.last   = last;
        sample_q.push_back(it);
    endtask

    task automatic settle();
        while (sample_q.size() > 0 || s_valid || resampled_q.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(input logic [lir_pkg::STEP_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random streams; some are left open and run into the next one
    task automatic random_streams(input int n_items);
        int count, len, pick, v;
        count = 0;
        while (count < n_items) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    v = $urandom_range(65535) - 32768;
                else if (pick < 90)
                    v = $urandom_range(128) - 64;
                else
                    v = $urandom_range(1) ? 32767 : -32768;
                push_item(v, (i == len - 1) && ($urandom_range(99) < 90));
            end
            count += len;
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        s_idle_pct = 27;
        m_idle_pct = 68;

        // reset step 1.0: pass-through, full-scale swings
        push_item(0, 0);
        push_item(32767, 0);
        push_item(-32768, 0);
        push_item(32767, 0);
        push_item(-1, 0);
        push_item(1, 1);
        // half step: midpoints, truncation toward zero on both signs
        write_step(lir_pkg::STEP_W'(32768));
        push_item(-32768, 0);
        push_item(32767, 0);
        push_item(-32768, 0);
        push_item(0, 0);
        push_item(-3, 0);
        push_item(3, 1);
        // above range clamps to 16; final input produces nothing, no last
        write_step(lir_pkg::STEP_W'(21'h1FFFFF));
        push_item(1, 0);
        push_item(2, 0);
        push_item(3, 1);
        // below range clamps to 1/32; lone final sample repeats
        write_step(lir_pkg::STEP_W'(0));
        push_item(-100, 1);
        // stream left open across a step change
        push_item(5, 0);
        push_item(-7, 0);
        write_step(lir_pkg::STEP_W'(98304));
        push_item(9, 0);
        push_item(-9, 1);

        write_step(lir_pkg::STEP_MIN);
        random_streams(25);
        hold_req = 1'b1;
        write_step(lir_pkg::STEP_W'($urandom_range(2048, 1048576)));
        random_streams(30);

        write_step(lir_pkg::STEP_MAX);
        s_idle_pct = 68;
        m_idle_pct = 27;
        random_streams(30);
        write_step(lir_pkg::STEP_RESET);
        random_streams(30);
        write_step(lir_pkg::STEP_W'($urandom_range(0, 2047)));
        random_streams(25);

        write_step(lir_pkg::STEP_W'($urandom_range(1048577, 2097151)));
        s_idle_pct = 0;
        m_idle_pct = 0;
        random_streams(30);
        write_step(lir_pkg::STEP_W'($urandom_range(2048, 1048576)));
        random_streams(30);
        write_step(lir_pkg::STEP_MIN);
        random_streams(20);

        settle();
        if (err_count == 0)
            $display("linear_interp_resampler regression: pass");
        else
            $display("linear_interp_resampler regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/lir_pkg.sv
design/lir_interp.sv
design/linear_interp_resampler.sv
test/linear_interp_resampler_tb.sv
